// File: rtl/ist_pkg.sv
// Shared types, codes and sizes for the integer set table.
`default_nettype none

package ist_pkg;

    // Table size default and dump limit
    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;

    // Field widths
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    // Operation codes on the input beat
    localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
    localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
    localparam logic [OP_W-1:0] OP_DUMP     = 3'd3;
    localparam logic [OP_W-1:0] OP_AT       = 3'd4;

    // Decoded command kind
    typedef enum logic [2:0] {
        K_ADD,
        K_REMOVE,
        K_CONTAINS,
        K_DUMP,
        K_AT,
        K_NOP
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_PRESENT = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // Back end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_AT,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RESP
    } t_state;

    // Classified command, front to back
    typedef struct packed {
        t_kind                     kind;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_cmd;

    // One result beat, back to top
    typedef struct packed {
        logic                      found;
        t_status                   status;
        logic [COUNT_W-1:0]        count;
        logic signed [VALUE_W-1:0] element;
        logic                      last;
    } t_res;

endpackage

`default_nettype wire

// File: rtl/ist_front.sv
// Input stage: takes input beats, decodes the operation and hands commands to the queue.
`default_nettype none

module ist_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [ist_pkg::OP_W-1:0]      i_op,
    input  wire logic signed [ist_pkg::VALUE_W-1:0] i_value,
    input  wire logic [ist_pkg::POS_W-1:0]     i_position,
    output logic                               o_push,
    output ist_pkg::t_cmd                      o_cmd,
    input  wire logic                          i_q_ready
);

    logic          r_valid;
    logic          n_valid;
    ist_pkg::t_cmd r_cmd;
    ist_pkg::t_kind kind;
    logic          accept;

    // Decode the op code, unknown codes become a no-op
    always_comb begin
        case (i_op)
            ist_pkg::OP_ADD:      kind = ist_pkg::K_ADD;
            ist_pkg::OP_REMOVE:   kind = ist_pkg::K_REMOVE;
            ist_pkg::OP_CONTAINS: kind = ist_pkg::K_CONTAINS;
            ist_pkg::OP_DUMP:     kind = ist_pkg::K_DUMP;
            ist_pkg::OP_AT:       kind = ist_pkg::K_AT;
            default:              kind = ist_pkg::K_NOP;
        endcase
    end

    // Hold one command until the queue takes it
    assign o_ready = !r_valid || i_q_ready;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_valid;
    assign o_cmd   = r_cmd;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_q_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture the payload on acceptance
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.kind     <= kind;
            r_cmd.value    <= i_value;
            r_cmd.position <= i_position;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ist_queue.sv
// Short command queue that decouples the input stage from the table sequencer.
`default_nettype none

module ist_queue (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire ist_pkg::t_cmd i_cmd,
    output logic       o_ready,
    output logic       o_valid,
    output ist_pkg::t_cmd o_cmd,
    input  wire logic  i_pop
);

    localparam int QD = ist_pkg::QUEUE_DEPTH;
    localparam int QA = ist_pkg::QUEUE_AW;

    ist_pkg::t_cmd r_slot [QD];
    logic [QA-1:0] r_wp;
    logic [QA-1:0] r_rp;
    logic [QA:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_cnt != QD[QA:0]);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ist_back.sv
// Table sequencer: owns the entry memory, scans, appends, shifts and emits results.
`default_nettype none

module ist_back #(
    parameter int DEPTH = ist_pkg::DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    input  wire ist_pkg::t_cmd i_q_cmd,
    output logic       o_q_pop,
    output logic       o_valid,
    output ist_pkg::t_res o_res,
    input  wire logic  i_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + ist_pkg::COUNT_W;
    localparam int PW = CW + ist_pkg::POS_W;

    // Entry memory and registered read port
    logic signed [ist_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic signed [ist_pkg::VALUE_W-1:0] r_rd_data;
    logic                               mem_we;
    logic [AW-1:0]                      mem_wa;
    logic signed [ist_pkg::VALUE_W-1:0] mem_wd;
    logic                               mem_re;
    logic [AW-1:0]                      mem_ra;

    ist_pkg::t_state  r_state,  n_state;
    ist_pkg::t_cmd    r_cmd,    n_cmd;
    logic [CW-1:0]    r_idx,    n_idx;
    logic             r_pend,   n_pend;
    logic [AW-1:0]    r_pend_idx, n_pend_idx;
    logic [CW-1:0]    r_count,  n_count;
    logic             r_found,  n_found;
    ist_pkg::t_status r_status, n_status;
    logic             r_out_valid, n_out_valid;
    ist_pkg::t_res    r_out,    n_out;

    logic                          out_free;
    logic                          hit;
    logic                          scan_end;
    logic [XW-1:0]                 idx_inc;
    logic                          dump_last;
    logic [CW+ist_pkg::COUNT_W-1:0] count_ext;
    logic [ist_pkg::COUNT_W-1:0]   count_out;
    logic [PW-1:0]                 pos_cmp;
    logic [PW-1:0]                 cnt_cmp;
    logic [AW+ist_pkg::POS_W-1:0]  pos_ext;
    logic [AW-1:0]                 pos_addr;

    assign out_free  = !r_out_valid || i_ready;
    assign hit       = r_pend && (r_rd_data == r_cmd.value);
    assign scan_end  = hit || (!r_pend && (r_idx >= r_count));
    assign idx_inc   = XW'(r_idx) + XW'(1);
    assign dump_last = (idx_inc == XW'(r_count)) || (idx_inc == XW'(ist_pkg::MAX_RESULTS));
    assign count_ext = {{ist_pkg::COUNT_W{1'b0}}, r_count};
    assign count_out = count_ext[ist_pkg::COUNT_W-1:0];
    assign pos_cmp   = {{CW{1'b0}}, r_cmd.position};
    assign cnt_cmp   = {{ist_pkg::POS_W{1'b0}}, r_count};
    assign pos_ext   = {{AW{1'b0}}, r_cmd.position};
    assign pos_addr  = pos_ext[AW-1:0];

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // Sequence each command over the memory
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_count     = r_count;
        n_found     = r_found;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = r_count[AW-1:0];
        mem_wd      = r_cmd.value;
        mem_re      = 1'b0;
        mem_ra      = r_idx[AW-1:0];

        case (r_state)
            ist_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_cmd    = i_q_cmd;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_found  = 1'b0;
                    n_status = ist_pkg::ST_OK;
                    case (i_q_cmd.kind)
                        ist_pkg::K_ADD, ist_pkg::K_CONTAINS: begin
                            n_state = ist_pkg::S_SCAN;
                        end
                        ist_pkg::K_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ist_pkg::ST_EMPTY;
                                n_state  = ist_pkg::S_RESP;
                            end else begin
                                n_state = ist_pkg::S_SCAN;
                            end
                        end
                        ist_pkg::K_DUMP: begin
                            if (r_count == '0) begin
                                n_status = ist_pkg::ST_EMPTY;
                                n_state  = ist_pkg::S_RESP;
                            end else begin
                                n_state = ist_pkg::S_DUMP_RD;
                            end
                        end
                        ist_pkg::K_AT: begin
                            n_state = ist_pkg::S_AT;
                        end
                        default: begin
                            n_state = ist_pkg::S_RESP;
                        end
                    endcase
                end
            end

            // Stream reads and compare one entry per cycle
            ist_pkg::S_SCAN: begin
                if (!scan_end) begin
                    if (r_idx < r_count) begin
                        mem_re     = 1'b1;
                        n_pend     = 1'b1;
                        n_pend_idx = r_idx[AW-1:0];
                        n_idx      = r_idx + 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                end else begin
                    n_pend  = 1'b0;
                    n_state = ist_pkg::S_RESP;
                    case (r_cmd.kind)
                        ist_pkg::K_ADD: begin
                            if (hit) begin
                                n_found  = 1'b1;
                                n_status = ist_pkg::ST_PRESENT;
                            end else if (r_count >= CW'(DEPTH)) begin
                                n_status = ist_pkg::ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        ist_pkg::K_REMOVE: begin
                            if (hit) begin
                                n_idx   = CW'(r_pend_idx) + CW'(1);
                                n_state = ist_pkg::S_SHIFT;
                            end else begin
                                n_status = ist_pkg::ST_ABSENT;
                            end
                        end
                        default: begin
                            n_found = hit;
                        end
                    endcase
                end
            end

            // Move the tail down one slot: read ahead, write behind
            ist_pkg::S_SHIFT: begin
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_pend_idx - 1'b1;
                    mem_wd = r_rd_data;
                end
                if (r_idx < r_count) begin
                    mem_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[AW-1:0];
                    n_idx      = r_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - 1'b1;
                        n_found = 1'b1;
                        n_state = ist_pkg::S_RESP;
                    end
                end
            end

            // Read the addressed entry if the position is below the count, then compare
            ist_pkg::S_AT: begin
                if (!r_pend) begin
                    if (pos_cmp < cnt_cmp) begin
                        mem_re = 1'b1;
                        mem_ra = pos_addr;
                        n_pend = 1'b1;
                    end else begin
                        n_state = ist_pkg::S_RESP;
                    end
                end else begin
                    n_pend  = 1'b0;
                    n_found = (r_rd_data == r_cmd.value);
                    n_state = ist_pkg::S_RESP;
                end
            end

            ist_pkg::S_DUMP_RD: begin
                mem_re  = 1'b1;
                n_state = ist_pkg::S_DUMP_OUT;
            end

            // Emit one stored entry when the output slot frees up
            ist_pkg::S_DUMP_OUT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out.found   = 1'b0;
                    n_out.status  = ist_pkg::ST_OK;
                    n_out.count   = count_out;
                    n_out.element = r_rd_data;
                    n_out.last    = dump_last;
                    if (dump_last) begin
                        n_state = ist_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ist_pkg::S_DUMP_RD;
                    end
                end
            end

            ist_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out.found   = r_found;
                    n_out.status  = r_status;
                    n_out.count   = count_out;
                    n_out.element = '0;
                    n_out.last    = 1'b1;
                    n_state       = ist_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ist_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ist_pkg::S_IDLE;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_found    <= n_found;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

endmodule

`default_nettype wire

// File: rtl/integer_set_table.sv
// Path: an accepted beat passes the input register and the command queue before it reaches
// the sequencer; add, contains and remove scan the stored entries (remove then shifts the tail down),
// contains-at reads one entry, and dump reads and emits one entry in turn; the single memory read
// port paces every scan. Throughput: one command at a time in the sequencer; up to three further
// beats are taken while it works.
// Reset: synchronous, active low; the table is empty at once, no clearing pass.
`default_nettype none

module integer_set_table #(
    parameter int DEPTH = ist_pkg::DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [ist_pkg::S_DATA_W-1:0] i_s_tdata,  // value[31:0], position[35:32], zero pad
    input  wire logic [ist_pkg::OP_W-1:0]     i_s_tuser,  // op[2:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [ist_pkg::M_DATA_W-1:0]      o_m_tdata,  // found[0], status[3:1], count[8:4],
                                                          // element[40:9], zero pad
    output logic             o_m_tlast
);

    logic          push;
    logic          q_ready;
    logic          q_valid;
    logic          q_pop;
    ist_pkg::t_cmd f_cmd;
    ist_pkg::t_cmd q_cmd;
    ist_pkg::t_res res;

    ist_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_op       (i_s_tuser),
        .i_value    (i_s_tdata[31:0]),
        .i_position (i_s_tdata[35:32]),
        .o_push     (push),
        .o_cmd      (f_cmd),
        .i_q_ready  (q_ready)
    );

    ist_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    ist_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .o_res     (res),
        .i_ready   (i_m_tready)
    );

    // Pack the result beat
    assign o_m_tdata = {7'b0, res.element, res.count, res.status, res.found};
    assign o_m_tlast = res.last;

endmodule

`default_nettype wire

// File: rtl/ist_chk.sv
// Port-level checker for the integer set table, bound to the top level.
`default_nettype none

module ist_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_s_tready,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [ist_pkg::M_DATA_W-1:0]  o_m_tdata,
    input wire logic                          o_m_tlast
);

    // Output beat holds while stalled
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result beat changed while stalled");

    // Any non-ok status ends its command at once
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[3:1] != ist_pkg::ST_OK) |-> o_m_tlast)
        else $error("error status on a non-final beat");

    // A dumped element carries no found flag and an ok status
    a_elem_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[40:9] != 32'd0) |->
        (o_m_tdata[0] == 1'b0) && (o_m_tdata[3:1] == ist_pkg::ST_OK))
        else $error("element with found or error status");

    // Found goes with ok or already present, and is always a single beat
    a_found_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |->
        o_m_tlast && ((o_m_tdata[3:1] == ist_pkg::ST_OK) ||
                      (o_m_tdata[3:1] == ist_pkg::ST_PRESENT)))
        else $error("found flag with wrong status");

    // Reset leaves the output empty and the input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("not idle after reset");

endmodule

bind integer_set_table ist_chk u_ist_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
